// ----- design/ctjq_pkg.sv -----
// Shared types and constants of the coalescing tile job queue.
`default_nettype none
package ctjq_pkg;

    localparam int TILE_W   = 53;
    localparam int COORD_W  = 24;
    localparam int ZOOM_W   = 5;
    localparam int REQ_W    = 8;
    localparam int WSEL_W   = 3;
    localparam int POOL_W   = 4;
    localparam int COUNT_W  = 5;

    localparam logic [POOL_W-1:0] POOL_RESET = 4'd4;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_DISPATCH = 2'd1,
        OP_RELEASE  = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        STAT_QUEUED      = 3'd0,
        STAT_MERGED      = 3'd1,
        STAT_PROMOTED    = 3'd2,
        STAT_REJECTED    = 3'd3,
        STAT_DISPATCHED  = 3'd4,
        STAT_NONE        = 3'd5,
        STAT_RELEASED    = 3'd6,
        STAT_IDLE_WORKER = 3'd7
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // queue row command, same for every cell
    typedef struct packed {
        logic cmp;
        logic push;
        logic promote;
        logic pop;
    } t_qctl;

    // worker row command, same for every cell
    typedef struct packed {
        logic cmp;
        logic assign_job;
        logic release_job;
    } t_wctl;

endpackage
`default_nettype wire

// ----- design/ctjq_queue_cell.sv -----
// One queue slot: holds a tile, compares it with a new key, shifts toward either neighbor.
`default_nettype none
module ctjq_queue_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ctjq_pkg::t_qctl             i_ctl,
    input  wire logic [ctjq_pkg::TILE_W-1:0] i_cmp_key,
    input  wire logic [ctjq_pkg::TILE_W-1:0] i_left_tile,
    input  wire logic                        i_left_valid,
    input  wire logic [ctjq_pkg::TILE_W-1:0] i_right_tile,
    input  wire logic                        i_right_valid,
    input  wire logic                        i_shl_right,
    output logic      [ctjq_pkg::TILE_W-1:0] o_tile,
    output logic                             o_valid,
    output logic                             o_shl
);

    logic [ctjq_pkg::TILE_W-1:0] r_tile;
    logic                        r_valid;
    logic                        r_match;
    logic                        ins;

    // this slot or one behind it holds the matching tile
    assign o_shl   = r_match | i_shl_right;
    assign ins     = (i_ctl.push & i_left_valid) | (i_ctl.promote & o_shl);
    assign o_tile  = r_tile;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_match <= r_valid & (r_tile == i_cmp_key);
            end
            if (i_ctl.pop) begin
                r_valid <= i_right_valid;
            end else if (ins) begin
                r_valid <= i_left_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_tile <= i_right_tile;
        end else if (ins) begin
            r_tile <= i_left_tile;
        end
    end

endmodule
`default_nettype wire

// ----- design/ctjq_worker_cell.sv -----
// One worker slot: busy flag and tile, with lowest-index pick chains for merge and free.
`default_nettype none
module ctjq_worker_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ctjq_pkg::t_wctl             i_ctl,
    input  wire logic [ctjq_pkg::TILE_W-1:0] i_cmp_key,
    input  wire logic [ctjq_pkg::TILE_W-1:0] i_job_tile,
    input  wire logic                        i_in_pool,
    input  wire logic                        i_rel_pick,
    input  wire logic                        i_merge_seen,
    input  wire logic                        i_free_seen,
    output logic                             o_merge_seen,
    output logic                             o_merge_sel,
    output logic                             o_free_seen,
    output logic                             o_free_sel,
    output logic                             o_busy
);

    logic [ctjq_pkg::TILE_W-1:0] r_tile;
    logic                        r_busy;
    logic                        r_match;
    logic                        avail;

    assign avail        = i_in_pool & ~r_busy;
    assign o_merge_seen = i_merge_seen | r_match;
    assign o_merge_sel  = r_match & ~i_merge_seen;
    assign o_free_seen  = i_free_seen | avail;
    assign o_free_sel   = avail & ~i_free_seen;
    assign o_busy       = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_match <= 1'b0;
        end else begin
            if (i_ctl.cmp) begin
                r_match <= r_busy & (r_tile == i_cmp_key);
            end
            if (i_ctl.assign_job && o_free_sel) begin
                r_busy <= 1'b1;
            end else if (i_ctl.release_job && i_rel_pick) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.assign_job && o_free_sel) begin
            r_tile <= i_job_tile;
        end
    end

endmodule
`default_nettype wire

// ----- design/coalescing_tile_job_queue_core.sv -----
// Top level of the coalescing tile job queue: control, queue row and worker row.
// On acceptance of a request every queue and worker cell compares its tile
// with the request key and registers the hit; in the execute state the lowest-index hit and free
// worker are picked along the cell chains, the queue row shifts by one slot where needed and the
// result is loaded into the output register. The update waits only while that register still holds a
// result not taken. A request is taken again in the cycle after the update, so no new request
// is taken while one is in flight. Opcode 3 passes the execute state and yields no result.
`default_nettype none
module coalescing_tile_job_queue_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_WORKERS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [23:0] i_tile_x,
    input  wire logic [23:0] i_tile_y,
    input  wire logic [4:0]  i_tile_zoom,
    input  wire logic [7:0]  i_requestor_id,
    input  wire logic [2:0]  i_worker_index,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_status,
    output logic [2:0]       o_out_worker,
    output logic [23:0]      o_out_tile_x,
    output logic [23:0]      o_out_tile_y,
    output logic [4:0]       o_out_tile_zoom,
    output logic [7:0]       o_out_requestor,
    output logic [4:0]       o_queue_count
);

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int WIDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int TW     = ctjq_pkg::TILE_W;

    ctjq_pkg::t_state  r_state, n_state;
    ctjq_pkg::t_opcode r_op;
    logic [ctjq_pkg::POOL_W-1:0] r_pool;
    logic [TW-1:0]     r_key;
    logic [7:0]        r_req;
    logic [2:0]        r_windex;
    logic [FILL_W-1:0] r_fill, n_fill;

    logic              r_out_valid, n_out_valid;
    logic [2:0]        r_status, n_status;
    logic [2:0]        r_worker, n_worker;
    logic [TW-1:0]     r_tile_out, n_tile_out;
    logic [7:0]        r_req_out, n_req_out;
    logic [4:0]        r_count_out, n_count_out;

    logic [TW-1:0]     in_key;
    logic              accept;
    logic              out_free;
    logic              load_out;

    ctjq_pkg::t_qctl   qctl;
    ctjq_pkg::t_wctl   wctl;

    logic [TW-1:0]          q_tile  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] q_valid;
    logic [QUEUE_DEPTH-1:0] q_shl;

    logic [MAX_WORKERS-1:0] w_busy;
    logic [MAX_WORKERS-1:0] w_merge_seen;
    logic [MAX_WORKERS-1:0] w_merge_sel;
    logic [MAX_WORKERS-1:0] w_free_seen;
    logic [MAX_WORKERS-1:0] w_free_sel;
    logic [MAX_WORKERS-1:0] w_in_pool;
    logic [MAX_WORKERS-1:0] w_rel_pick;

    logic [WIDX_W-1:0] merge_idx;
    logic [WIDX_W-1:0] free_idx;
    logic              rel_hit;

    assign in_key     = {i_tile_zoom, i_tile_y, i_tile_x};
    assign o_in_ready = (r_state == ctjq_pkg::S_IDLE);
    assign accept     = i_in_valid & o_in_ready;
    assign out_free   = ~r_out_valid | i_out_ready;

    // queue row, front of the queue at slot 0
    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_q
        logic [TW-1:0] left_tile, right_tile;
        logic          left_valid, right_valid, shl_right;
        if (k == 0) begin : g_first
            assign left_tile  = r_key;
            assign left_valid = 1'b1;
        end else begin : g_mid
            assign left_tile  = q_tile[k-1];
            assign left_valid = q_valid[k-1];
        end
        if (k == QUEUE_DEPTH - 1) begin : g_last
            assign right_tile  = q_tile[k];
            assign right_valid = 1'b0;
            assign shl_right   = 1'b0;
        end else begin : g_inner
            assign right_tile  = q_tile[k+1];
            assign right_valid = q_valid[k+1];
            assign shl_right   = q_shl[k+1];
        end
        ctjq_queue_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (qctl),
            .i_cmp_key    (in_key),
            .i_left_tile  (left_tile),
            .i_left_valid (left_valid),
            .i_right_tile (right_tile),
            .i_right_valid(right_valid),
            .i_shl_right  (shl_right),
            .o_tile       (q_tile[k]),
            .o_valid      (q_valid[k]),
            .o_shl        (q_shl[k])
        );
    end

    // worker row, pick chains run from worker 0 upward
    for (genvar k = 0; k < MAX_WORKERS; k++) begin : g_w
        logic merge_in, free_in;
        if (k == 0) begin : g_first
            assign merge_in = 1'b0;
            assign free_in  = 1'b0;
        end else begin : g_mid
            assign merge_in = w_merge_seen[k-1];
            assign free_in  = w_free_seen[k-1];
        end
        assign w_in_pool[k]  = (int'(r_pool) > k);
        assign w_rel_pick[k] = (k < 8) && (r_windex == 3'(k));
        ctjq_worker_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (wctl),
            .i_cmp_key   (in_key),
            .i_job_tile  (q_tile[0]),
            .i_in_pool   (w_in_pool[k]),
            .i_rel_pick  (w_rel_pick[k]),
            .i_merge_seen(merge_in),
            .i_free_seen (free_in),
            .o_merge_seen(w_merge_seen[k]),
            .o_merge_sel (w_merge_sel[k]),
            .o_free_seen (w_free_seen[k]),
            .o_free_sel  (w_free_sel[k]),
            .o_busy      (w_busy[k])
        );
    end

    always_comb begin
        merge_idx = '0;
        free_idx  = '0;
        for (int k = 0; k < MAX_WORKERS; k++) begin
            if (w_merge_sel[k]) merge_idx |= WIDX_W'(k);
            if (w_free_sel[k])  free_idx  |= WIDX_W'(k);
        end
    end

    assign rel_hit = |(w_rel_pick & w_busy);

    always_comb begin
        n_state    = r_state;
        n_fill     = r_fill;
        qctl       = '0;
        wctl       = '0;
        load_out   = 1'b0;
        n_status   = ctjq_pkg::STAT_QUEUED;
        n_worker   = '0;
        n_tile_out = '0;
        n_req_out  = '0;
        unique case (r_state)
            ctjq_pkg::S_IDLE: begin
                qctl.cmp = accept;
                wctl.cmp = accept;
                if (accept) n_state = ctjq_pkg::S_EXEC;
            end
            ctjq_pkg::S_EXEC: begin
                unique case (r_op)
                    ctjq_pkg::OP_ADD: begin
                        n_req_out = r_req;
                        if (out_free) begin
                            load_out = 1'b1;
                            n_state  = ctjq_pkg::S_IDLE;
                            priority if (w_merge_seen[MAX_WORKERS-1]) begin
                                n_status = ctjq_pkg::STAT_MERGED;
                                n_worker = 3'(merge_idx);
                            end else if (q_shl[0]) begin
                                n_status     = ctjq_pkg::STAT_PROMOTED;
                                qctl.promote = 1'b1;
                            end else if (q_valid[QUEUE_DEPTH-1]) begin
                                n_status = ctjq_pkg::STAT_REJECTED;
                            end else begin
                                n_status  = ctjq_pkg::STAT_QUEUED;
                                qctl.push = 1'b1;
                                n_fill    = r_fill + FILL_W'(1);
                            end
                        end
                    end
                    ctjq_pkg::OP_DISPATCH: begin
                        if (out_free) begin
                            load_out = 1'b1;
                            n_state  = ctjq_pkg::S_IDLE;
                            if (q_valid[0] && w_free_seen[MAX_WORKERS-1]) begin
                                n_status        = ctjq_pkg::STAT_DISPATCHED;
                                n_worker        = 3'(free_idx);
                                n_tile_out      = q_tile[0];
                                qctl.pop        = 1'b1;
                                wctl.assign_job = 1'b1;
                                n_fill          = r_fill - FILL_W'(1);
                            end else begin
                                n_status = ctjq_pkg::STAT_NONE;
                            end
                        end
                    end
                    ctjq_pkg::OP_RELEASE: begin
                        if (out_free) begin
                            load_out = 1'b1;
                            n_state  = ctjq_pkg::S_IDLE;
                            n_worker = r_windex;
                            if (rel_hit) begin
                                n_status         = ctjq_pkg::STAT_RELEASED;
                                wctl.release_job = 1'b1;
                            end else begin
                                n_status = ctjq_pkg::STAT_IDLE_WORKER;
                            end
                        end
                    end
                    default: n_state = ctjq_pkg::S_IDLE;
                endcase
            end
            default: n_state = ctjq_pkg::S_IDLE;
        endcase
    end

    assign n_count_out = 5'(n_fill);
    assign n_out_valid = load_out | (r_out_valid & ~i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ctjq_pkg::S_IDLE;
            r_fill      <= '0;
            r_pool      <= ctjq_pkg::POOL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) r_pool <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= ctjq_pkg::t_opcode'(i_opcode);
            r_key    <= in_key;
            r_req    <= i_requestor_id;
            r_windex <= i_worker_index;
        end
        if (load_out) begin
            r_status    <= n_status;
            r_worker    <= n_worker;
            r_tile_out  <= n_tile_out;
            r_req_out   <= n_req_out;
            r_count_out <= n_count_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_out_worker    = r_worker;
    assign o_out_tile_x    = r_tile_out[23:0];
    assign o_out_tile_y    = r_tile_out[47:24];
    assign o_out_tile_zoom = r_tile_out[52:48];
    assign o_out_requestor = r_req_out;
    assign o_queue_count   = r_count_out;

endmodule
`default_nettype wire

// ----- design/ctjq_checker.sv -----
// Port-level checks of the tile job queue, bound to the top level.
`default_nettype none
module ctjq_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  o_status,
    input wire logic [2:0]  o_out_worker,
    input wire logic [23:0] o_out_tile_x,
    input wire logic [23:0] o_out_tile_y,
    input wire logic [4:0]  o_out_tile_zoom,
    input wire logic [7:0]  o_out_requestor
);

    // nothing is shown right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // one request in flight: the input is closed in the cycle after a request is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while another is being worked");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
            && $stable(o_out_worker) && $stable(o_out_tile_x))
        else $error("stalled result changed");

    // only a dispatch carries a tile, and only worker outcomes carry a worker
    a_field_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == 3'd0 || o_status == 3'd2 || o_status == 3'd3
            || o_status == 3'd5)
        |-> o_out_worker == 3'd0 && o_out_tile_x == 24'd0 && o_out_tile_y == 24'd0
            && o_out_tile_zoom == 5'd0)
        else $error("stray worker or tile on a result");

    a_req_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == 3'd4 || o_status == 3'd5 || o_status == 3'd6
            || o_status == 3'd7)
        |-> o_out_requestor == 8'd0)
        else $error("requestor echoed on a non-add result");

endmodule

bind coalescing_tile_job_queue_core ctjq_checker u_ctjq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_status       (o_status),
    .o_out_worker   (o_out_worker),
    .o_out_tile_x   (o_out_tile_x),
    .o_out_tile_y   (o_out_tile_y),
    .o_out_tile_zoom(o_out_tile_zoom),
    .o_out_requestor(o_out_requestor)
);
`default_nettype wire

// ----- dv/tb_coalescing_tile_job_queue_core.sv -----
// Self-checking testbench for the coalescing tile job queue core.
module tb_coalescing_tile_job_queue_core;

    localparam int QUEUE_DEPTH  = 16;
    localparam int MAX_WORKERS  = 8;
    localparam int DRAIN_CYCLES = 4;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 160;
    localparam int COORD_W      = ctjq_pkg::COORD_W;
    localparam int ZOOM_W       = ctjq_pkg::ZOOM_W;
    localparam int REQ_W        = ctjq_pkg::REQ_W;
    localparam int WSEL_W       = ctjq_pkg::WSEL_W;
    localparam int POOL_W       = ctjq_pkg::POOL_W;
    localparam int COUNT_W      = ctjq_pkg::COUNT_W;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [ZOOM_W-1:0]  z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_tile;

    typedef struct packed {
        ctjq_pkg::t_status  status;
        logic [WSEL_W-1:0]  worker;
        t_tile              tile;
        logic [REQ_W-1:0]   requestor;
        logic [COUNT_W-1:0] count;
    } t_outcome;

    class job_queue_scoreboard;
        t_tile    waiting[QUEUE_DEPTH];
        int       fill;
        bit       busy[MAX_WORKERS];
        t_tile    held[MAX_WORKERS];
        int       pool;
        t_outcome outcomes_due[$];
        int       errors;
        int       requests;
        int       checked;
        int       status_seen[8];

        function new();
            fill = 0;
            pool = int'(ctjq_pkg::POOL_RESET);
            errors = 0;
            requests = 0;
            checked = 0;
            foreach (busy[i]) busy[i] = 1'b0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void set_pool(logic [POOL_W-1:0] size);
            pool = int'(size);
        endfunction

        function int pending();
            return outcomes_due.size();
        endfunction

        // Advance the job queue model by one accepted request.
        function void note_request(logic [1:0] op, t_tile t, logic [REQ_W-1:0] req,
                                   logic [WSEL_W-1:0] widx);
            t_outcome r;
            int hit;
            int lim;
            int w;
            int i;
            requests++;
            if (op == OP_UNUSED) return;
            r = '0;
            case (op)
                ctjq_pkg::OP_ADD: begin
                    r.requestor = req;
                    hit = -1;
                    for (i = 0; i < MAX_WORKERS; i++)
                        if (hit < 0 && busy[i] && held[i] == t) hit = i;
                    if (hit >= 0) begin
                        r.status = ctjq_pkg::STAT_MERGED;
                        r.worker = 3'(hit);
                    end else begin
                        for (i = 0; i < fill; i++)
                            if (hit < 0 && waiting[i] == t) hit = i;
                        if (hit >= 0) begin
                            for (i = hit; i > 0; i--) waiting[i] = waiting[i-1];
                            waiting[0] = t;
                            r.status = ctjq_pkg::STAT_PROMOTED;
                        end else if (fill >= QUEUE_DEPTH) begin
                            r.status = ctjq_pkg::STAT_REJECTED;
                        end else begin
                            for (i = fill; i > 0; i--) waiting[i] = waiting[i-1];
                            waiting[0] = t;
                            fill++;
                            r.status = ctjq_pkg::STAT_QUEUED;
                        end
                    end
                end
                ctjq_pkg::OP_DISPATCH: begin
                    lim = (pool < MAX_WORKERS) ? pool : MAX_WORKERS;
                    w = lim;
                    for (i = lim - 1; i >= 0; i--)
                        if (!busy[i]) w = i;
                    if (fill == 0 || w >= lim) begin
                        r.status = ctjq_pkg::STAT_NONE;
                    end else begin
                        r.tile = waiting[0];
                        for (i = 0; i < fill - 1; i++) waiting[i] = waiting[i+1];
                        fill--;
                        busy[w] = 1'b1;
                        held[w] = r.tile;
                        r.status = ctjq_pkg::STAT_DISPATCHED;
                        r.worker = 3'(w);
                    end
                end
                default: begin
                    r.worker = widx;
                    if (busy[widx]) begin
                        busy[widx] = 1'b0;
                        r.status = ctjq_pkg::STAT_RELEASED;
                    end else begin
                        r.status = ctjq_pkg::STAT_IDLE_WORKER;
                    end
                end
            endcase
            r.count = COUNT_W'(fill);
            outcomes_due = {outcomes_due, r};
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_outcome got);
            t_outcome want;
            if (outcomes_due.size() == 0) begin
                $error("result with no request waiting: status %0d", got.status);
                errors++;
                return;
            end
            want = outcomes_due[0];
            outcomes_due.delete(0);
            checked++;
            status_seen[want.status]++;
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("out_worker", 64'(want.worker), 64'(got.worker));
            compare_field("out_tile_x", 64'(want.tile.x), 64'(got.tile.x));
            compare_field("out_tile_y", 64'(want.tile.y), 64'(got.tile.y));
            compare_field("out_tile_zoom", 64'(want.tile.z), 64'(got.tile.z));
            compare_field("out_requestor", 64'(want.requestor), 64'(got.requestor));
            compare_field("queue_count", 64'(want.count), 64'(got.count));
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [POOL_W-1:0]    i_cfg_wdata;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [1:0]           i_opcode;
    logic [COORD_W-1:0]   i_tile_x;
    logic [COORD_W-1:0]   i_tile_y;
    logic [ZOOM_W-1:0]    i_tile_zoom;
    logic [REQ_W-1:0]     i_requestor_id;
    logic [WSEL_W-1:0]    i_worker_index;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [2:0]           o_status;
    logic [WSEL_W-1:0]    o_out_worker;
    logic [COORD_W-1:0]   o_out_tile_x;
    logic [COORD_W-1:0]   o_out_tile_y;
    logic [ZOOM_W-1:0]    o_out_tile_zoom;
    logic [REQ_W-1:0]     o_out_requestor;
    logic [COUNT_W-1:0]   o_queue_count;

    job_queue_scoreboard sb;
    int quiet_cycles;
    bit long_hold_done;
    logic [COORD_W-1:0] hot_x[3];
    logic [COORD_W-1:0] hot_y[3];
    logic [ZOOM_W-1:0]  hot_z[3];

    coalescing_tile_job_queue_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .MAX_WORKERS(MAX_WORKERS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_tile_x       (i_tile_x),
        .i_tile_y       (i_tile_y),
        .i_tile_zoom    (i_tile_zoom),
        .i_requestor_id (i_requestor_id),
        .i_worker_index (i_worker_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_out_worker   (o_out_worker),
        .o_out_tile_x   (o_out_tile_x),
        .o_out_tile_y   (o_out_tile_y),
        .o_out_tile_zoom(o_out_tile_zoom),
        .o_out_requestor(o_out_requestor),
        .o_queue_count  (o_queue_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Results are checked before the request of the same edge is noted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_result({ctjq_pkg::t_status'(o_status), o_out_worker,
                                 {o_out_tile_zoom, o_out_tile_y, o_out_tile_x},
                                 o_out_requestor, o_queue_count});
            if (i_in_valid && o_in_ready)
                sb.note_request(i_opcode, {i_tile_zoom, i_tile_y, i_tile_x},
                                i_requestor_id, i_worker_index);
            if (i_cfg_we)
                sb.set_pool(i_cfg_wdata);
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("** coalescing_tile_job_queue_core: FAILED **");
        $finish;
    end

    // Receiver: segments of steady, random and stalled ready, plus one long hold.
    initial begin : result_sink
        int mode;
        int len;
        i_out_ready = 1'b0;
        long_hold_done = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!long_hold_done && sb.checked >= 300) begin
                long_hold_done = 1'b1;
                repeat (LONG_HOLD) begin
                    @(negedge i_clk);
                    i_out_ready = 1'b0;
                end
            end
            mode = $urandom_range(0, 3);
            len = (mode == 3) ? $urandom_range(1, 10) : $urandom_range(1, 40);
            repeat (len) begin
                @(negedge i_clk);
                case (mode)
                    0: i_out_ready = 1'b1;
                    1: i_out_ready = 1'($urandom_range(0, 1));
                    2: i_out_ready = ($urandom_range(0, 7) != 0);
                    default: i_out_ready = 1'b0;
                endcase
            end
        end
    end

    function automatic t_tile random_tile();
        t_tile t;
        t.x = COORD_W'($urandom);
        t.y = COORD_W'($urandom);
        t.z = ZOOM_W'($urandom);
        return t;
    endfunction

    // Mostly a small hot set so that merges, promotions and a full queue occur.
    function automatic t_tile pick_tile();
        t_tile t;
        if ($urandom_range(0, 99) < 15) return random_tile();
        t.x = hot_x[$urandom_range(0, 2)];
        t.y = hot_y[$urandom_range(0, 2)];
        t.z = hot_z[$urandom_range(0, 2)];
        return t;
    endfunction

    task automatic send_request(input logic [1:0] op, input t_tile t,
                                input logic [REQ_W-1:0] req, input logic [WSEL_W-1:0] widx);
        @(negedge i_clk);
        i_in_valid     = 1'b1;
        i_opcode       = op;
        i_tile_x       = t.x;
        i_tile_y       = t.y;
        i_tile_zoom    = t.z;
        i_requestor_id = req;
        i_worker_index = widx;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic hold_off(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
    endtask

    task automatic write_pool_size(input logic [POOL_W-1:0] size);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        // an unused opcode may still be in flight with nothing expected
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = size;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic run_phase(input int items);
        int sent;
        int burst;
        int wa;
        int wd;
        int wr;
        int roll;
        wa = $urandom_range(1, 10);
        wd = $urandom_range(1, 10);
        wr = $urandom_range(1, 10);
        hot_x[2] = COORD_W'($urandom);
        hot_y[2] = COORD_W'($urandom);
        hot_z[2] = ZOOM_W'($urandom);
        sent = 0;
        burst = $urandom_range(1, 60);
        while (sent < items) begin
            if ($urandom_range(0, 99) < 3) begin
                send_request(OP_UNUSED, random_tile(), REQ_W'($urandom), WSEL_W'($urandom));
            end else begin
                roll = $urandom_range(0, wa + wd + wr - 1);
                if (roll < wa)
                    send_request(ctjq_pkg::OP_ADD, pick_tile(), REQ_W'($urandom),
                                 WSEL_W'($urandom));
                else if (roll < wa + wd)
                    send_request(ctjq_pkg::OP_DISPATCH, random_tile(), REQ_W'($urandom),
                                 WSEL_W'($urandom));
                else
                    send_request(ctjq_pkg::OP_RELEASE, random_tile(), REQ_W'($urandom),
                                 WSEL_W'($urandom));
                sent++;
            end
            burst--;
            if (burst == 0) begin
                hold_off($urandom_range(1, 12));
                burst = $urandom_range(1, 60);
            end
        end
    endtask

    initial begin : main_seq
        t_tile tile_ones;
        t_tile tile_zero;
        logic [POOL_W-1:0] pools[8];
        sb = new();
        quiet_cycles = 0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        i_in_valid     = 1'b0;
        i_opcode       = ctjq_pkg::OP_ADD;
        i_tile_x       = '0;
        i_tile_y       = '0;
        i_tile_zoom    = '0;
        i_requestor_id = '0;
        i_worker_index = '0;
        hot_x = '{24'hFFFFFF, 24'h0, 24'h0};
        hot_y = '{24'hFFFFFF, 24'h0, 24'h0};
        hot_z = '{5'h1F, 5'h0, 5'h0};
        tile_ones = '1;
        tile_zero = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed, reset pool of four
        send_request(ctjq_pkg::OP_DISPATCH, random_tile(), 8'hFF, 3'd7);   // nothing queued
        send_request(ctjq_pkg::OP_RELEASE, tile_ones, 8'h00, 3'd0);        // idle worker
        send_request(ctjq_pkg::OP_ADD, tile_ones, 8'hFF, 3'd0);
        send_request(ctjq_pkg::OP_ADD, tile_zero, 8'h00, 3'd7);
        send_request(ctjq_pkg::OP_ADD, tile_ones, 8'hA5, 3'd0);            // promote
        send_request(ctjq_pkg::OP_DISPATCH, tile_zero, 8'h00, 3'd0);
        send_request(ctjq_pkg::OP_ADD, tile_ones, 8'h5A, 3'd0);            // merge into busy
        repeat (15)
            send_request(ctjq_pkg::OP_ADD, random_tile(), REQ_W'($urandom), WSEL_W'($urandom));
        // full, rejected
        send_request(ctjq_pkg::OP_ADD, random_tile(), REQ_W'($urandom), WSEL_W'($urandom));
        send_request(ctjq_pkg::OP_ADD, tile_zero, 8'h3C, 3'd0);            // promote while full
        send_request(ctjq_pkg::OP_RELEASE, random_tile(), 8'h00, 3'd0);
        send_request(OP_UNUSED, tile_ones, 8'hFF, 3'd7);

        pools = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd2, 4'($urandom_range(0, 15)), 4'd8, 4'd3};
        foreach (pools[p]) begin
            write_pool_size(pools[p]);
            run_phase(PHASE_ITEMS);
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d requests over pool sizes 0 to 15, %0d results checked",
                 sb.requests, sb.checked);
        $display("queued %0d merged %0d promoted %0d rejected %0d",
                 sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
        $display("dispatched %0d none %0d released %0d idle %0d",
                 sb.status_seen[4], sb.status_seen[5], sb.status_seen[6], sb.status_seen[7]);
        if (sb.errors == 0)
            $display("** coalescing_tile_job_queue_core: PASSED **");
        else
            $display("** coalescing_tile_job_queue_core: FAILED **");
        $finish;
    end

endmodule
